### design/wqss_pkg.sv
// ============================================================================
// wqss_pkg
// Shared sizes, field widths and codes for the waiting queue with service
// slots.
// ============================================================================
package wqss_pkg;

    // Storage sizes.
    localparam int QUEUE_DEPTH = 256;
    localparam int NUM_BOXES   = 16;
    localparam int ID_WIDTH    = 32;

    // Fixed field widths of the stream items and the register.
    localparam int KIND_W    = 2;
    localparam int AGENT_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int BOX_W     = 4;
    localparam int FILLED_W  = 5;
    localparam int WAITING_W = 9;
    localparam int CFG_W     = 5;
    localparam int OUT_W     = STATUS_W + BOX_W + FILLED_W + WAITING_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Derived internal widths.
    localparam int ID_W    = (ID_WIDTH < AGENT_W) ? ID_WIDTH : AGENT_W;
    localparam int QD_AW   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_AW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
    localparam int SLOT_CW = $clog2(NUM_BOXES + 1);

    // Transaction kinds.
    typedef enum logic [KIND_W-1:0] {
        K_ENQUEUE = 2'd0,
        K_DEQUEUE = 2'd1,
        K_QUERY   = 2'd2,
        K_FILL    = 2'd3
    } t_kind;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Register reset value: every slot active.
    localparam logic [CFG_W-1:0] BOXES_RESET = CFG_W'(NUM_BOXES);

endpackage

### design/waiting_queue_with_service_slots_core.sv
// ============================================================================
// waiting_queue_with_service_slots_core
// FIFO wait list of client ids in a ring memory plus a table of service
// slots that are searched, freed and filled by transaction kind.
// ============================================================================
// Each input transaction gives exactly one result. An enqueue, a query and a
// dequeue that frees a slot are accepted in the idle state and load the
// result register in the execute state. A dequeue that has to remove the id
// from the wait list streams the list through the registered read port of the
// wait-list memory and writes the kept ids back in place. A fill visits the
// active slots in order until the list is empty, steps past each busy slot
// and assigns each free one by reading the head of the list and then writing
// the slot. One transaction is worked on at a time; a new one is
// accepted while a finished result still waits on the output, and it waits
// for that result to leave before its own result is loaded.
module waiting_queue_with_service_slots_core
    import wqss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration: active slot count.
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // Input stream.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [AGENT_W-1:0]     i_s_tdata,   // [31:0] client_id
    input  logic [KIND_W-1:0]      i_s_tuser,   // [1:0] kind
    // Result stream.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [1:0] status, [5:2] box_index,
                                                // [10:6] filled_count,
                                                // [19:11] waiting, rest zero
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FILL_RD,
        S_FILL_WR
    } t_state;

    // Ring address: base plus offset, wrapped at the queue depth.
    function automatic logic [QD_AW-1:0] wrap_add(input logic [QD_AW-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[QD_AW-1:0];
    endfunction

    // Wait-list memory.
    logic [ID_W-1:0]        mem [QUEUE_DEPTH];
    logic                   mem_we;
    logic [QD_AW-1:0]       mem_waddr;
    logic [QD_AW-1:0]       mem_raddr;
    logic [ID_W-1:0]        mem_wdata;
    logic [ID_W-1:0]        r_rdata;

    // Control and queue state.
    t_state                 r_state;
    t_kind                  r_kind;
    logic [ID_W-1:0]        r_id;
    logic [QD_AW-1:0]       r_head;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_rd;
    logic [CNT_W-1:0]       r_wr;
    logic                   r_chk;
    logic [SLOT_CW-1:0]     r_slot;
    logic [FILLED_W-1:0]    r_filled;
    logic [CFG_W-1:0]       r_boxes;

    // Slot table.
    logic [NUM_BOXES-1:0]   r_busy;
    logic [ID_W-1:0]        r_holder [NUM_BOXES];

    // Result register.
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_st;
    logic [BOX_W-1:0]       r_box;
    logic [FILLED_W-1:0]    r_fill_out;
    logic [WAITING_W-1:0]   r_waiting;

    logic                   out_free;
    logic [SLOT_CW-1:0]     active;
    logic                   hit;
    logic [SLOT_AW-1:0]     hit_idx;
    logic                   scan_keep;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - OUT_W)'(0), r_waiting, r_fill_out, r_box, r_st};

    // Active slot count, clamped to the table size.
    always_comb begin
        if (r_boxes > CFG_W'(NUM_BOXES)) begin
            active = SLOT_CW'(NUM_BOXES);
        end else begin
            active = SLOT_CW'(r_boxes);
        end
    end

    // Lowest active busy slot that holds the current id.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_BOXES - 1; i >= 0; i--) begin
            if (r_busy[i] && (r_holder[i] == r_id) && (SLOT_CW'(i) < active)) begin
                hit     = 1'b1;
                hit_idx = SLOT_AW'(i);
            end
        end
    end

    assign scan_keep = r_chk && (r_rdata != r_id);

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wrap_add(r_head, r_count);
        mem_wdata = r_id;
        mem_raddr = r_head;
        case (r_state)
            S_EXEC: begin
                if (r_kind == K_ENQUEUE && out_free &&
                    r_count < CNT_W'(QUEUE_DEPTH)) begin
                    mem_we = 1'b1;
                end
            end
            S_SCAN: begin
                mem_raddr = wrap_add(r_head, r_rd);
                if (scan_keep) begin
                    mem_we    = 1'b1;
                    mem_waddr = wrap_add(r_head, r_wr);
                    mem_wdata = r_rdata;
                end
            end
            default: begin
                mem_raddr = r_head;
            end
        endcase
    end

    // Wait-list memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Sequencer, slot table and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_head      <= '0;
            r_busy      <= '0;
            r_boxes     <= BOXES_RESET;
            r_chk       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_boxes <= i_cfg_wdata;
            end
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind  <= t_kind'(i_s_tuser);
                        r_id    <= i_s_tdata[ID_W-1:0];
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    if (out_free) begin
                        r_box      <= '0;
                        r_fill_out <= '0;
                        r_st       <= ST_OK;
                        r_waiting  <= WAITING_W'(r_count);
                        case (r_kind)
                            K_ENQUEUE: begin
                                r_out_valid <= 1'b1;
                                r_state     <= S_IDLE;
                                if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                                    r_st <= ST_FULL;
                                end else begin
                                    r_count   <= r_count + 1'b1;
                                    r_waiting <= WAITING_W'(r_count + 1'b1);
                                end
                            end
                            K_DEQUEUE: begin
                                if (hit) begin
                                    r_busy[hit_idx] <= 1'b0;
                                    r_out_valid     <= 1'b1;
                                    r_state         <= S_IDLE;
                                end else begin
                                    r_rd    <= '0;
                                    r_wr    <= '0;
                                    r_chk   <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end
                            K_QUERY: begin
                                r_out_valid <= 1'b1;
                                r_state     <= S_IDLE;
                                if (hit) begin
                                    r_box <= BOX_W'(hit_idx);
                                end else begin
                                    r_st <= ST_NOT_FOUND;
                                end
                            end
                            default: begin
                                r_slot   <= '0;
                                r_filled <= '0;
                                r_state  <= S_FILL_RD;
                            end
                        endcase
                    end
                end

                // Stream the list out and write kept ids back, closing gaps.
                S_SCAN: begin
                    r_chk <= (r_rd < r_count);
                    if (r_rd < r_count) begin
                        r_rd <= r_rd + 1'b1;
                    end
                    if (scan_keep) begin
                        r_wr <= r_wr + 1'b1;
                    end
                    if (r_rd >= r_count && !r_chk && out_free) begin
                        r_out_valid <= 1'b1;
                        r_st        <= (r_wr == r_count) ? ST_NOT_FOUND : ST_OK;
                        r_box       <= '0;
                        r_fill_out  <= '0;
                        r_waiting   <= WAITING_W'(r_wr);
                        r_count     <= r_wr;
                        r_state     <= S_IDLE;
                    end
                end

                // Look for the next free active slot; the head read is issued here.
                S_FILL_RD: begin
                    if (r_slot >= active || r_count == '0) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_st        <= ST_OK;
                            r_box       <= '0;
                            r_fill_out  <= r_filled;
                            r_waiting   <= WAITING_W'(r_count);
                            r_state     <= S_IDLE;
                        end
                    end else if (r_busy[r_slot[SLOT_AW-1:0]]) begin
                        r_slot <= r_slot + 1'b1;
                    end else begin
                        r_state <= S_FILL_WR;
                    end
                end

                // Hand the oldest waiting id to the slot and pop the list head.
                S_FILL_WR: begin
                    r_holder[r_slot[SLOT_AW-1:0]] <= r_rdata;
                    r_busy[r_slot[SLOT_AW-1:0]]   <= 1'b1;
                    r_head   <= wrap_add(r_head, CNT_W'(1));
                    r_count  <= r_count - 1'b1;
                    r_filled <= r_filled + 1'b1;
                    r_slot   <= r_slot + 1'b1;
                    r_state  <= S_FILL_RD;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
